FILE: design/ssdp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stepper step/dir pulse sequencer.
// No dependencies; used by ssdp_ctrl and the top level.

package ssdp_pkg;

  // field widths
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned REPEAT_W = 16;
  localparam int unsigned SPEED_W  = 3;
  localparam int unsigned DELAY_W  = 7;

  // timing in ticks
  localparam logic [DELAY_W-1:0] SETTLE_TICKS = DELAY_W'(10);
  localparam logic [DELAY_W-1:0] PAUSE_TICKS  = DELAY_W'(100);
  localparam logic [SPEED_W-1:0] SPEED_MAX    = SPEED_W'(5);

  // input opcodes
  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_START_CW    = 2'd1,
    OP_START_CCW   = 2'd2,
    OP_START_CYCLE = 2'd3
  } op_e;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_LOW    = 3'd2,
    PH_HIGH   = 3'd3,
    PH_PAUSE  = 3'd4
  } phase_e;

  // input word
  typedef struct packed {
    op_e                 opcode;
    logic [SPEED_W-1:0]  speed_level;
    logic [STEP_W-1:0]   step_count;
    logic [REPEAT_W-1:0] repeat_count;
  } ssdp_in_t;

  // result word
  typedef struct packed {
    logic dir_level;
    logic step_level;
    logic busy_res;
    logic start_rejected;
  } ssdp_out_t;

  // half period in ticks: (6 - speed) * 10 + 5, speed saturated at 5
  function automatic logic [DELAY_W-1:0] half_period_of(logic [SPEED_W-1:0] speed);
    logic [DELAY_W-1:0] hp;
    case ((speed > SPEED_MAX) ? SPEED_MAX : speed)
      3'd0:    hp = DELAY_W'(65);
      3'd1:    hp = DELAY_W'(55);
      3'd2:    hp = DELAY_W'(45);
      3'd3:    hp = DELAY_W'(35);
      3'd4:    hp = DELAY_W'(25);
      default: hp = DELAY_W'(15);
    endcase
    return hp;
  endfunction

endpackage

FILE: design/stepper_step_dir_pulse_sequencer_core.sv
`timescale 1ns / 1ps
// Top level of the stepper step/dir pulse sequencer: input register,
// sequencer update and result register. Depends on ssdp_pkg and ssdp_ctrl.

// Each input word is a 1 us tick or a start command; every word yields one
// result word with the direction and step pin levels, busy and start-rejected.
// A word is held in the input register, where it is applied to the
// sequencer state, and moves into the result register, which raises
// result valid, once that register is free or being taken. A new word is
// taken in every cycle while the result side keeps up. The sequencer
// state update is a single pass of narrow counter logic per word, which
// sets that rate.
module stepper_step_dir_pulse_sequencer_core import ssdp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ssdp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ssdp_out_t out_data_o
);

  ssdp_in_t  in_q;
  logic      in_vld_q;
  ssdp_out_t out_q;
  logic      out_vld_q;
  ssdp_out_t res;
  logic      fire;

  // word moves from input register to result register
  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  ssdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_fire_i (fire),
    .item_i      (in_q),
    .res_o       (res)
  );

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/ssdp_ctrl.sv
`timescale 1ns / 1ps
// Sequencer state and per-word update logic: pin levels, phase, counters.
// Depends on ssdp_pkg.

module ssdp_ctrl import ssdp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_fire_i,
  input  ssdp_in_t  item_i,
  output ssdp_out_t res_o
);

  phase_e              phase_q, phase_d;
  logic [DELAY_W-1:0]  delay_left_q, delay_left_d;
  logic [DELAY_W-1:0]  half_period_q, half_period_d;
  logic [STEP_W-1:0]   steps_left_q, steps_left_d;
  logic [STEP_W-1:0]   step_total_q, step_total_d;
  logic [REPEAT_W-1:0] repeats_left_q, repeats_left_d;
  logic                cycle_mode_q, cycle_mode_d;
  logic                dir_pin_q, dir_pin_d;
  logic                step_pin_q, step_pin_d;

  // next state
  always_comb begin
    logic [DELAY_W-1:0]  dly_dec;
    logic [STEP_W-1:0]   steps_v;
    logic [REPEAT_W-1:0] reps_v;
    phase_d        = phase_q;
    delay_left_d   = delay_left_q;
    half_period_d  = half_period_q;
    steps_left_d   = steps_left_q;
    step_total_d   = step_total_q;
    repeats_left_d = repeats_left_q;
    cycle_mode_d   = cycle_mode_q;
    dir_pin_d      = dir_pin_q;
    step_pin_d     = step_pin_q;
    dly_dec = (delay_left_q != '0) ? delay_left_q - DELAY_W'(1) : delay_left_q;
    steps_v = (phase_q == PH_HIGH) ? steps_left_q - STEP_W'(1) : steps_left_q;
    reps_v  = repeats_left_q - REPEAT_W'(1);
    if (item_fire_i) begin
      if (item_i.opcode == OP_TICK) begin
        if (phase_q != PH_IDLE) begin
          delay_left_d = dly_dec;
          if (dly_dec == '0) begin
            case (phase_q)
              PH_SETTLE, PH_HIGH: begin
                steps_left_d = steps_v;
                if (steps_v != '0) begin
                  step_pin_d   = 1'b0;
                  delay_left_d = half_period_q;
                  phase_d      = PH_LOW;
                end else if (cycle_mode_q) begin
                  delay_left_d = PAUSE_TICKS;
                  phase_d      = PH_PAUSE;
                end else begin
                  phase_d = PH_IDLE;
                end
              end
              PH_LOW: begin
                step_pin_d   = 1'b1;
                delay_left_d = half_period_q;
                phase_d      = PH_HIGH;
              end
              PH_PAUSE: begin
                if (!dir_pin_q) begin
                  dir_pin_d    = 1'b1;
                  steps_left_d = step_total_q;
                  delay_left_d = SETTLE_TICKS;
                  phase_d      = PH_SETTLE;
                end else begin
                  repeats_left_d = reps_v;
                  if (reps_v == '0) begin
                    phase_d = PH_IDLE;
                  end else begin
                    dir_pin_d    = 1'b0;
                    steps_left_d = step_total_q;
                    delay_left_d = SETTLE_TICKS;
                    phase_d      = PH_SETTLE;
                  end
                end
              end
              default: phase_d = PH_IDLE;
            endcase
          end
        end
      end else if (phase_q == PH_IDLE) begin
        // accepted start
        half_period_d = half_period_of(item_i.speed_level);
        step_total_d  = item_i.step_count;
        cycle_mode_d  = (item_i.opcode == OP_START_CYCLE);
        if (item_i.opcode == OP_START_CYCLE) begin
          repeats_left_d = item_i.repeat_count;
        end
        if (item_i.opcode != OP_START_CYCLE || item_i.repeat_count != '0) begin
          dir_pin_d    = (item_i.opcode == OP_START_CW);
          steps_left_d = item_i.step_count;
          delay_left_d = SETTLE_TICKS;
          phase_d      = PH_SETTLE;
        end
      end
    end
  end

  // result word
  always_comb begin
    res_o.dir_level      = dir_pin_d;
    res_o.step_level     = step_pin_d;
    res_o.busy_res       = (phase_d != PH_IDLE);
    res_o.start_rejected = (item_i.opcode != OP_TICK) && (phase_q != PH_IDLE);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      delay_left_q   <= '0;
      half_period_q  <= '0;
      steps_left_q   <= '0;
      step_total_q   <= '0;
      repeats_left_q <= '0;
      cycle_mode_q   <= 1'b0;
      dir_pin_q      <= 1'b0;
      step_pin_q     <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      delay_left_q   <= delay_left_d;
      half_period_q  <= half_period_d;
      steps_left_q   <= steps_left_d;
      step_total_q   <= step_total_d;
      repeats_left_q <= repeats_left_d;
      cycle_mode_q   <= cycle_mode_d;
      dir_pin_q      <= dir_pin_d;
      step_pin_q     <= step_pin_d;
    end
  end

`ifndef ASSERT_OFF
  // a rejected start leaves the phase alone
  a_reject_keeps_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_fire_i && res_o.start_rejected) |=> (phase_q == $past(phase_q)))
    else $error("rejected start changed the phase");

  // a tick while idle leaves the pins alone
  a_idle_tick_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_fire_i && item_i.opcode == OP_TICK && phase_q == PH_IDLE)
    |=> ($stable(dir_pin_q) && $stable(step_pin_q)))
    else $error("idle tick moved a pin");

  // step pin follows the pulse half
  a_low_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LOW) |-> !step_pin_q)
    else $error("step pin high in low half");

  a_high_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HIGH) |-> step_pin_q)
    else $error("step pin low in high half");

  // a running phase always has time left
  a_delay_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (delay_left_q != '0))
    else $error("running phase with zero delay");
`endif

endmodule

FILE: tb/ssdp_pin_checker.sv
`timescale 1ns / 1ps
// Pin-level checker for the stepper step/dir pulse sequencer: watches both
// word channels, predicts pin levels per accepted input word and compares.
// Depends on ssdp_pkg for the word types, phases and timing constants.

module ssdp_pin_checker import ssdp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  ssdp_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  ssdp_out_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  // predicted sequencer state
  phase_e              seq_phase;
  logic [DELAY_W-1:0]  ticks_left;
  logic [DELAY_W-1:0]  half_ticks;
  logic [STEP_W-1:0]   pulses_left;
  logic [STEP_W-1:0]   pulse_total;
  logic [REPEAT_W-1:0] laps_left;
  logic                back_forth;
  logic                dir_q;
  logic                step_q;

  ssdp_out_t expected_pins[$];
  ssdp_out_t want_pins;
  ssdp_out_t next_pins;
  int        fail_count = 0;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] pin mismatch: %s", $time, what);
  endtask

  task automatic check_pin(input string name, input logic got, input logic want);
    if (got !== want) report_mismatch($sformatf("%s got %b want %b", name, got, want));
  endtask

  // set direction and wait out the settle time
  task automatic begin_run(input logic cw);
    dir_q       = cw;
    pulses_left = pulse_total;
    ticks_left  = SETTLE_TICKS;
    seq_phase   = PH_SETTLE;
  endtask

  // next low half of a pulse, or the end of this direction run
  task automatic next_pulse_or_end();
    if (pulses_left != '0) begin
      step_q     = 1'b0;
      ticks_left = half_ticks;
      seq_phase  = PH_LOW;
    end else if (back_forth) begin
      ticks_left = PAUSE_TICKS;
      seq_phase  = PH_PAUSE;
    end else begin
      seq_phase = PH_IDLE;
    end
  endtask

  // one microsecond of pin timing
  task automatic tick_pins();
    if (seq_phase != PH_IDLE) begin
      if (ticks_left != '0) ticks_left--;
      if (ticks_left == '0) begin
        case (seq_phase)
          PH_SETTLE: next_pulse_or_end();
          PH_LOW: begin
            step_q     = 1'b1;
            ticks_left = half_ticks;
            seq_phase  = PH_HIGH;
          end
          PH_HIGH: begin
            pulses_left--;
            next_pulse_or_end();
          end
          PH_PAUSE: begin
            // ccw leg done: go cw; cw leg done: one lap less
            if (!dir_q) begin
              begin_run(1'b1);
            end else begin
              laps_left--;
              if (laps_left == '0) seq_phase = PH_IDLE;
              else begin_run(1'b0);
            end
          end
          default: seq_phase = PH_IDLE;
        endcase
      end
    end
  endtask

  // pin levels after one input word
  task automatic predict_pins(input ssdp_in_t w, output ssdp_out_t r);
    logic [SPEED_W-1:0] spd;
    logic               rejected;
    rejected = 1'b0;
    if (w.opcode == OP_TICK) begin
      tick_pins();
    end else if (seq_phase != PH_IDLE) begin
      rejected = 1'b1;
    end else begin
      spd         = (w.speed_level > SPEED_MAX) ? SPEED_MAX : w.speed_level;
      half_ticks  = DELAY_W'((6 - int'(spd)) * 10 + 5);
      pulse_total = w.step_count;
      back_forth  = (w.opcode == OP_START_CYCLE);
      if (w.opcode == OP_START_CW) begin
        begin_run(1'b1);
      end else if (w.opcode == OP_START_CCW) begin
        begin_run(1'b0);
      end else begin
        // zero laps leaves the block idle, start is still taken
        laps_left = w.repeat_count;
        if (w.repeat_count != '0) begin_run(1'b0);
      end
    end
    r.dir_level      = dir_q;
    r.step_level     = step_q;
    r.busy_res       = (seq_phase != PH_IDLE);
    r.start_rejected = rejected;
  endtask

  // compare results first, then take in the new word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_phase    = PH_IDLE;
      ticks_left   = '0;
      half_ticks   = '0;
      pulses_left  = '0;
      pulse_total  = '0;
      laps_left    = '0;
      back_forth   = 1'b0;
      dir_q        = 1'b0;
      step_q       = 1'b0;
      expected_pins.delete();
      pending_o    <= 0;
      fail_count_o <= fail_count;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_pins.size() == 0) begin
          report_mismatch("result word with no input word waiting");
        end else begin
          want_pins = expected_pins.pop_front();
          check_pin("dir_level", out_data_i.dir_level, want_pins.dir_level);
          check_pin("step_level", out_data_i.step_level, want_pins.step_level);
          check_pin("busy_res", out_data_i.busy_res, want_pins.busy_res);
          check_pin("start_rejected", out_data_i.start_rejected, want_pins.start_rejected);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_pins(in_data_i, next_pins);
        expected_pins.push_back(next_pins);
      end
      pending_o    <= expected_pins.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the stepper step/dir pulse sequencer testbench: clock, reset,
// motion command and tick stimulus, result-side stalls and the verdict.
// Depends on ssdp_pkg, stepper_step_dir_pulse_sequencer_core, ssdp_pin_checker.

module testbench;
  import ssdp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          ITEM_BUDGET = 400;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  ssdp_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ssdp_out_t out_data;
  int        fail_count;
  int        pending;

  int          words_sent    = 0;
  int          busy_ticks    = 0;
  bit          sender_burst  = 1'b0;
  int          stall_left    = 0;
  bit          rx_steady     = 1'b0;
  int unsigned cycle_count   = 0;

  stepper_step_dir_pulse_sequencer_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  ssdp_pin_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // idle span: mostly short, a few long
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // result side stalls, with stretches of steady ready
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) rx_steady = ~rx_steady;
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rx_steady || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      stall_left = idle_span() - 1;
      out_ready <= 1'b0;
    end
  end

  function automatic op_e pick_start_op();
    case ($urandom_range(0, 4))
      0, 1:    return OP_START_CW;
      2, 3:    return OP_START_CCW;
      default: return OP_START_CYCLE;
    endcase
  endfunction

  // ticks from an accepted start until the block is idle again
  function automatic int ticks_to_idle(input ssdp_in_t w);
    int spd;
    int run;
    spd = (w.speed_level > SPEED_MAX) ? int'(SPEED_MAX) : int'(w.speed_level);
    run = 10 + 2 * ((6 - spd) * 10 + 5) * int'(w.step_count);
    if (w.opcode == OP_START_CYCLE) return int'(w.repeat_count) * (2 * run + 200);
    return run;
  endfunction

  // well-formed start with short runs; zero laps carry a wide step count
  function automatic ssdp_in_t random_start();
    ssdp_in_t w;
    int       pick;
    w.opcode       = pick_start_op();
    w.speed_level  = SPEED_W'($urandom_range(0, 7));
    w.repeat_count = REPEAT_W'($urandom);
    pick           = int'($urandom_range(0, 9));
    if (w.opcode == OP_START_CYCLE) begin
      w.step_count = STEP_W'($urandom_range(0, 2));
      if (pick < 2) begin
        w.repeat_count = '0;
        w.step_count   = STEP_W'($urandom);
      end else if (pick < 9) begin
        w.repeat_count = REPEAT_W'($urandom_range(1, 2));
      end else begin
        w.repeat_count = REPEAT_W'(3);
      end
    end else begin
      w.step_count = (pick < 8) ? STEP_W'($urandom_range(0, 3))
                                : STEP_W'($urandom_range(4, 8));
    end
    return w;
  endfunction

  task automatic send_word(input ssdp_in_t w);
    int gap;
    gap = (sender_burst || $urandom_range(0, 99) < 65) ? 0 : idle_span();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // a start only takes effect when the block is idle
  task automatic start_motion(input ssdp_in_t w);
    send_word(w);
    if (busy_ticks == 0) busy_ticks = ticks_to_idle(w);
  endtask

  // ticks with random payload; stray starts only land while busy
  task automatic run_ticks(input int count, input int stray_pct);
    ssdp_in_t w;
    repeat (count) begin
      if (busy_ticks > 0 && $urandom_range(0, 99) < stray_pct) begin
        w.opcode       = pick_start_op();
        w.speed_level  = SPEED_W'($urandom);
        w.step_count   = STEP_W'($urandom);
        w.repeat_count = REPEAT_W'($urandom);
        start_motion(w);
      end
      w.opcode       = OP_TICK;
      w.speed_level  = SPEED_W'($urandom);
      w.step_count   = STEP_W'($urandom);
      w.repeat_count = REPEAT_W'($urandom);
      send_word(w);
      if (busy_ticks > 0) busy_ticks--;
    end
  endtask

  task automatic directed_motion(input op_e op, input int spd, input int cnt, input int rep);
    ssdp_in_t w;
    w.opcode       = op;
    w.speed_level  = SPEED_W'(spd);
    w.step_count   = STEP_W'(cnt);
    w.repeat_count = REPEAT_W'(rep);
    start_motion(w);
    run_ticks(busy_ticks, 0);
  endtask

  // hold off the sender until every result word is back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    ssdp_in_t w;
    int       need;
    int       seq_count;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ticks while idle, all-zero and all-one payloads
    send_word('0);
    w        = '1;
    w.opcode = OP_TICK;
    send_word(w);

    // saturated speed, with starts rejected mid-run
    w              = '0;
    w.opcode       = OP_START_CW;
    w.speed_level  = SPEED_W'(7);
    w.step_count   = STEP_W'(1);
    start_motion(w);
    run_ticks(5, 0);
    start_motion('1);
    w.opcode = OP_START_CCW;
    start_motion(w);
    run_ticks(busy_ticks, 0);

    // zero step count ends right after settle
    directed_motion(OP_START_CW, 5, 0, 16'hFFFF);
    // back-and-forth with zero laps stays idle
    directed_motion(OP_START_CYCLE, 6, 16'hFFFF, 0);
    run_ticks(2, 0);
    // one lap of back-and-forth, one pulse each way
    directed_motion(OP_START_CYCLE, 5, 1, 1);
    wait_for_results();

    // random motion sequences, some cut short so the next start is rejected
    seq_count = 0;
    while (words_sent < ITEM_BUDGET) begin
      sender_burst = ($urandom_range(0, 9) < 3);
      start_motion(random_start());
      need = busy_ticks;
      if (need > 0 && $urandom_range(0, 9) == 0) need = int'($urandom_range(0, need - 1));
      // keep the whole run near the word budget
      if (need > ITEM_BUDGET - words_sent) need = ITEM_BUDGET - words_sent;
      run_ticks(need, 3);
      run_ticks(int'($urandom_range(0, 3)), 3);
      seq_count++;
      if (seq_count % 25 == 0) wait_for_results();
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
